/* src/sha1_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Types, round constants and helpers shared by the SHA-1 digest core and
// its channel interfaces.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  widx_t;
	typedef logic [5:0]  bpos_t;
	typedef logic [6:0]  rnd_t;
	typedef logic [63:0] bitcnt_t;

	localparam int unsigned NUM_WORDS  = 5;
	localparam int unsigned SCHED_LEN  = 16;
	localparam rnd_t        LAST_ROUND = 7'd79;
	localparam bpos_t       LAST_POS   = 6'd63;
	localparam bpos_t       LEN_POS    = 6'd56;
	localparam widx_t       LAST_WORD  = 3'd4;
	localparam byte_t       PAD_MARK   = 8'h80;
	localparam bitcnt_t     BYTE_BITS  = 64'd8;

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	localparam word_t INIT_H [NUM_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	function automatic word_t rotl5(input word_t v);
		return {v[26:0], v[31:27]};
	endfunction

	function automatic word_t rotl30(input word_t v);
		return {v[1:0], v[31:2]};
	endfunction

	function automatic word_t rotl1(input word_t v);
		return {v[30:0], v[31]};
	endfunction

	// Round constant by round number (four bands of 20)
	function automatic word_t round_k(input rnd_t t);
		word_t k;
		if (t < 7'd20) begin
			k = K0;
		end else if (t < 7'd40) begin
			k = K1;
		end else if (t < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	// Boolean function by round number
	function automatic word_t round_f(input rnd_t t, input word_t b, input word_t c,
			input word_t d);
		word_t f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40 || t >= 7'd60) begin
			f = b ^ c ^ d;
		end else begin
			f = (b & c) | (b & d) | (c & d);
		end
		return f;
	endfunction

endpackage
`default_nettype wire

/* src/sha1_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha1 channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_msg_if;
	import sha1_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	byte_t data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface sha1_digest_if;
	import sha1_pkg::*;

	logic  valid;
	logic  ready;
	word_t digest_word;
	widx_t word_index;
	logic  last;

	modport source (output valid, output digest_word, output word_index, output last,
		input ready);
	modport sink   (input valid, input digest_word, input word_index, input last,
		output ready);
endinterface
`default_nettype wire

/* src/sha1_message_digest_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 over a byte stream: one shared round unit, 80 rounds per block.
// ----------------------------------------------------------------------------
// Data byte: taken only in IDLE_S; the byte that fills a block starts the
//   rounds on the single shared round unit (ROUND_S), then the hash update (ADD_S).
// End of message: padding/length bytes are written in PAD_S (64 - pos, plus
//   64 when an extra block is needed), each full block is compressed, then 5
//   digest word transfers, one per cycle when the sink is ready.
// Reset: hash returns to the SHA-1 initial values, byte and bit counts to 0.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sha1_msg_if.sink      msg,
	sha1_digest_if.source digest
);
	import sha1_pkg::*;

	typedef enum logic [2:0] {
		IDLE_S,
		PAD_S,
		ROUND_S,
		ADD_S,
		EMIT_S
	} state_t;

	state_t  state_q;
	word_t   hash_q [NUM_WORDS];
	bpos_t   pos_q;
	bitcnt_t bit_count_q;
	rnd_t    rnd_q;
	widx_t   idx_q;
	logic    pad_q;      // end-of-message padding in progress
	logic    first_q;    // next pad byte is the 0x80 marker
	logic    len_ok_q;   // this block takes the length field
	logic    final_q;    // block being compressed is the last one

	word_t   word_q;
	word_t   sched_q [SCHED_LEN];
	word_t   wv_q [NUM_WORDS];

	logic    wr_en;
	byte_t   wr_byte;
	byte_t   pad_byte;
	logic    block_full;
	logic    word_full;
	logic    sched_shift;
	word_t   sched_in;
	word_t   sched_next;
	word_t   round_tmp;
	logic    in_xfer;
	logic    out_xfer;
	logic [2:0] len_k;

	assign msg.ready          = (state_q == IDLE_S);
	assign in_xfer            = msg.valid && msg.ready;
	assign digest.valid       = (state_q == EMIT_S);
	assign digest.digest_word = hash_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last        = (idx_q == LAST_WORD);
	assign out_xfer           = digest.valid && digest.ready;

	// Length bytes go out big-endian at buffer positions 56..63
	assign len_k = 3'd7 - pos_q[2:0];

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q && pos_q >= LEN_POS) begin
			pad_byte = bit_count_q[{len_k, 3'b000} +: 8];
		end else begin
			pad_byte = '0;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_byte = pad_byte;
		case (state_q)
			IDLE_S: begin
				wr_en   = in_xfer && !msg.action;
				wr_byte = msg.data_byte;
			end
			PAD_S: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign block_full = wr_en && (pos_q == LAST_POS);
	assign word_full  = wr_en && (pos_q[1:0] == 2'd3);

	// Schedule window is a shift line: slot 0 holds W[t] during round t
	assign sched_next  = rotl1(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0]);
	assign sched_shift = word_full || (state_q == ROUND_S);
	assign sched_in    = (state_q == ROUND_S) ? sched_next : {word_q[23:0], wr_byte};

	assign round_tmp = rotl5(wv_q[0]) + round_f(rnd_q, wv_q[1], wv_q[2], wv_q[3])
		+ wv_q[4] + sched_q[0] + round_k(rnd_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_q <= {word_q[23:0], wr_byte};
		end
		if (sched_shift) begin
			for (int i = 0; i < SCHED_LEN - 1; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[SCHED_LEN - 1] <= sched_in;
		end
		if (block_full) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (state_q == ROUND_S) begin
			wv_q[0] <= round_tmp;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= rotl30(wv_q[1]);
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE_S;
			for (int i = 0; i < NUM_WORDS; i++) begin
				hash_q[i] <= INIT_H[i];
			end
			pos_q       <= '0;
			bit_count_q <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (block_full) begin
				rnd_q <= '0;
			end
			case (state_q)
				IDLE_S: begin
					if (in_xfer) begin
						if (msg.action) begin
							state_q  <= PAD_S;
							pad_q    <= 1'b1;
							first_q  <= 1'b1;
							len_ok_q <= (pos_q < LEN_POS);
						end else begin
							bit_count_q <= bit_count_q + BYTE_BITS;
							if (block_full) begin
								state_q <= ROUND_S;
							end
						end
					end
				end
				PAD_S: begin
					first_q <= 1'b0;
					if (block_full) begin
						state_q <= ROUND_S;
						if (len_ok_q) begin
							final_q <= 1'b1;
						end else begin
							len_ok_q <= 1'b1;
						end
					end
				end
				ROUND_S: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ADD_S;
					end
				end
				ADD_S: begin
					for (int i = 0; i < NUM_WORDS; i++) begin
						hash_q[i] <= hash_q[i] + wv_q[i];
					end
					if (final_q) begin
						state_q <= EMIT_S;
						idx_q   <= '0;
					end else if (pad_q) begin
						state_q <= PAD_S;
					end else begin
						state_q <= IDLE_S;
					end
				end
				EMIT_S: begin
					if (out_xfer) begin
						if (idx_q == LAST_WORD) begin
							state_q     <= IDLE_S;
							for (int i = 0; i < NUM_WORDS; i++) begin
								hash_q[i] <= INIT_H[i];
							end
							pos_q       <= '0;
							bit_count_q <= '0;
							pad_q       <= 1'b0;
							final_q     <= 1'b0;
							len_ok_q    <= 1'b0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= IDLE_S;
				end
			endcase
		end
	end

	// Never take a byte while a digest word is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> !msg.ready)
		else $error("input ready while digest valid");

	// Filling the last buffer slot starts compression
	a_block_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !msg.action && pos_q == LAST_POS) |=> (state_q == ROUND_S && rnd_q == '0))
		else $error("full block did not start compression");

	// Round counter stays within the 80 rounds
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROUND_S) |-> (rnd_q <= LAST_ROUND))
		else $error("round counter out of range");

	// Digest words leave in order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !digest.last) |=> (digest.valid && idx_q == $past(idx_q) + 3'd1))
		else $error("digest word order broken");

	// After the last word the chaining hash and bit count restart
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && digest.last) |=> (hash_q[0] == INIT_H[0] && bit_count_q == '0
			&& pos_q == '0))
		else $error("state not restarted after digest");

endmodule
`default_nettype wire
